// ----- rtl/core/assert_macros.svh -----
// Assertion helpers for the controller core.
// Both expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define TDP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TDP_NEVER(lbl, cond, msg) \
    `TDP_ASSERT(lbl, !(cond), msg)
`else
`define TDP_ASSERT(lbl, prop, msg)
`define TDP_NEVER(lbl, cond, msg)
`endif
`endif

// ----- rtl/core/tdp_pkg.sv -----
package tdp_pkg;

    localparam int FRAC_BITS = 16;
    localparam bit SATURATE  = 1'b1;
    localparam int DIV_W     = 32 + FRAC_BITS;
    localparam int CNT_W     = $clog2(DIV_W);

    localparam logic signed [31:0] FX_ONE = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [31:0] FX_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] FX_MIN = 32'sh8000_0000;

    localparam logic [1:0] SAT_LOW  = 2'b11;
    localparam logic [1:0] SAT_FREE = 2'b00;
    localparam logic [1:0] SAT_HIGH = 2'b01;

    typedef enum logic [1:0] {
        CMD_STANDBY = 2'd0,
        CMD_ARM     = 2'd1,
        CMD_HOLD    = 2'd2,
        CMD_ENGAGE  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        REG_PROP_GAIN    = 3'd0,
        REG_INTEG_GAIN   = 3'd1,
        REG_DERIV_GAIN   = 3'd2,
        REG_FILTER_CONST = 3'd3,
        REG_PROP_WEIGHT  = 3'd4,
        REG_DERIV_WEIGHT = 3'd5,
        REG_UPPER_LIMIT  = 3'd6,
        REG_LOWER_LIMIT  = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic               start;
        logic signed [31:0] dividend;
        logic signed [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic signed [31:0] quotient;
    } div_rsp_t;

    // Clamp a wide signed value into 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'(FX_MAX)) begin
            r = FX_MAX;
        end
        else if (v < 64'(FX_MIN)) begin
            r = FX_MIN;
        end
        else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/tdp_channels.sv -----
interface tdp_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic signed [31:0] reference;
    logic signed [31:0] feedback;
    logic [30:0]        time_step;

    modport source (output valid, command, reference, feedback, time_step, input ready);
    modport sink (input valid, command, reference, feedback, time_step, output ready);
endinterface

interface tdp_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] drive_value;
    logic signed [1:0]  sat_status;

    modport source (output valid, drive_value, sat_status, input ready);
    modport sink (input valid, drive_value, sat_status, output ready);
endinterface

// ----- rtl/core/tdp_mul.sv -----
module tdp_mul (
    input  logic               clk,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    output logic signed [31:0] result
);

    logic signed [63:0] prod_reg;
    logic signed [63:0] shifted;

    // Register the full product
    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    // Floor shift to the fixed point, then clamp
    assign shifted = prod_reg >>> tdp_pkg::FRAC_BITS;
    assign result  = tdp_pkg::sat32(shifted);

endmodule

// ----- rtl/core/tdp_div.sv -----
module tdp_div (
    input  logic                clk,
    input  logic                rst_n,
    input  tdp_pkg::div_req_t   req,
    output tdp_pkg::div_rsp_t   rsp
);

    logic                        busy_reg;
    logic                        done_reg;
    logic                        neg_reg;
    logic [tdp_pkg::CNT_W-1:0]   cnt_reg;
    logic [31:0]                 rem_reg;
    logic [31:0]                 dvs_reg;
    logic [tdp_pkg::DIV_W-1:0]   quo_reg;
    logic signed [31:0]          res_reg;

    logic [31:0]                 ua;
    logic [31:0]                 ub;
    logic [32:0]                 trial;
    logic                        ge;
    logic [32:0]                 diff;
    logic [tdp_pkg::DIV_W-1:0]   quo_next;
    logic signed [31:0]          res_next;

    // Magnitudes of the operands
    assign ua = req.dividend[31] ? 32'(32'sd0 - req.dividend) : req.dividend;
    assign ub = req.divisor[31] ? 32'(32'sd0 - req.divisor) : req.divisor;

    // One restoring step per cycle
    assign trial    = {rem_reg, quo_reg[tdp_pkg::DIV_W-1]};
    assign ge       = trial >= {1'b0, dvs_reg};
    assign diff     = trial - {1'b0, dvs_reg};
    assign quo_next = {quo_reg[tdp_pkg::DIV_W-2:0], ge};

    // Apply sign and clamp the final quotient
    always_comb
    begin
        if (!neg_reg) begin
            if (quo_next[tdp_pkg::DIV_W-1:31] != '0) begin
                res_next = tdp_pkg::FX_MAX;
            end
            else begin
                res_next = quo_next[31:0];
            end
        end
        else begin
            if (quo_next[tdp_pkg::DIV_W-1:32] != '0 ||
                (quo_next[31] && quo_next[30:0] != '0)) begin
                res_next = tdp_pkg::FX_MIN;
            end
            else begin
                res_next = 32'(32'sd0 - signed'(quo_next[31:0]));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            neg_reg  <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
            quo_reg  <= '0;
            res_reg  <= '0;
        end
        else begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg) begin
                if (req.divisor == 32'sd0) begin
                    // Zero divisor gives zero
                    res_reg  <= '0;
                    done_reg <= 1'b1;
                end
                else begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= '0;
                    rem_reg  <= '0;
                    dvs_reg  <= ub;
                    neg_reg  <= req.dividend[31] ^ req.divisor[31];
                    quo_reg  <= {ua, {tdp_pkg::FRAC_BITS{1'b0}}};
                end
            end
            else if (busy_reg) begin
                rem_reg <= ge ? diff[31:0] : trial[31:0];
                quo_reg <= quo_next;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == tdp_pkg::CNT_W'(tdp_pkg::DIV_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    res_reg  <= res_next;
                end
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = res_reg;

endmodule

// ----- rtl/core/two_dof_pid_controller_core.sv -----
// Standby goes straight to the output; other commands run the full sequence, with up to
// four divisions (48 quotient bits, one per cycle, in the shared divider).
// Throughput: one transaction at a time; the next is taken once the result is queued.
// Multiplies go through one shared registered 32x32 multiplier, one per cycle.
// Reset (rst_n, async low) clears all state, loads register defaults, empties output.
module two_dof_pid_controller_core (
    input  logic        clk,
    input  logic        rst_n,
    tdp_in_if.sink      in_ch,
    tdp_out_if.source   out_ch,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    typedef enum logic [14:0] {
        ST_IDLE = 15'h0001,
        ST_PW   = 15'h0002,
        ST_DW   = 15'h0004,
        ST_PP   = 15'h0008,
        ST_D1   = 15'h0010,
        ST_D2   = 15'h0020,
        ST_POST = 15'h0040,
        ST_DI   = 15'h0080,
        ST_UPD  = 15'h0100,
        ST_UPW  = 15'h0200,
        ST_O1   = 15'h0400,
        ST_O2   = 15'h0800,
        ST_O3   = 15'h1000,
        ST_DC   = 15'h2000,
        ST_FIN  = 15'h4000
    } state_t;

    state_t state_reg, state_next;

    logic signed [31:0] pg_reg, ig_reg, dg_reg, fc_reg, pw_reg, dw_reg, ul_reg, ll_reg;

    logic [1:0]         cmd_reg, cmd_next;
    logic signed [31:0] ref_reg, ref_next;
    logic signed [31:0] fb_reg, fb_next;
    logic [30:0]        dt_reg, dt_next;
    logic signed [31:0] ierr_reg, ierr_next;
    logic signed [31:0] perr_reg, perr_next;
    logic signed [31:0] derr_reg, derr_next;
    logic signed [31:0] pp_reg, pp_next;
    logic signed [31:0] term_reg, term_next;
    logic signed [31:0] ib_reg, ib_next;
    logic signed [31:0] prev_reg, prev_next;
    logic signed [31:0] integ_reg, integ_next;
    logic               latch_reg, latch_next;
    logic signed [31:0] last_drive_reg, last_drive_next;
    logic [1:0]         last_sat_reg, last_sat_next;
    logic               out_valid_reg, out_valid_next;
    logic signed [31:0] out_drive_reg, out_drive_next;
    logic [1:0]         out_sat_reg, out_sat_next;

    logic signed [31:0] mul_a, mul_b, mul_res;
    tdp_pkg::div_req_t  div_req;
    tdp_pkg::div_rsp_t  div_rsp;

    logic               in_fire;
    logic signed [63:0] change;
    logic signed [31:0] filt;
    logic signed [31:0] sum;
    logic signed [31:0] clamped;
    logic signed [31:0] dt_s;

    tdp_mul u_mul (
        .clk    (clk),
        .a      (mul_a),
        .b      (mul_b),
        .result (mul_res)
    );

    tdp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign in_ch.ready        = (state_reg == ST_IDLE);
    assign in_fire            = in_ch.valid && in_ch.ready;
    assign out_ch.valid       = out_valid_reg;
    assign out_ch.drive_value = out_drive_reg;
    assign out_ch.sat_status  = out_sat_reg;
    assign dt_s               = signed'({1'b0, dt_reg});

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pg_reg <= tdp_pkg::FX_ONE;
            ig_reg <= '0;
            dg_reg <= '0;
            fc_reg <= '0;
            pw_reg <= tdp_pkg::FX_ONE;
            dw_reg <= tdp_pkg::FX_ONE;
            ul_reg <= '0;
            ll_reg <= '0;
        end
        else if (cfg_we) begin
            case (tdp_pkg::reg_idx_t'(cfg_index))
                tdp_pkg::REG_PROP_GAIN:    pg_reg <= cfg_data;
                tdp_pkg::REG_INTEG_GAIN:   ig_reg <= cfg_data;
                tdp_pkg::REG_DERIV_GAIN:   dg_reg <= cfg_data;
                tdp_pkg::REG_FILTER_CONST: fc_reg <= cfg_data;
                tdp_pkg::REG_PROP_WEIGHT:  pw_reg <= cfg_data;
                tdp_pkg::REG_DERIV_WEIGHT: dw_reg <= cfg_data;
                tdp_pkg::REG_UPPER_LIMIT:  ul_reg <= cfg_data;
                tdp_pkg::REG_LOWER_LIMIT:  ll_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer and datapath next state
    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        ref_next        = ref_reg;
        fb_next         = fb_reg;
        dt_next         = dt_reg;
        ierr_next       = ierr_reg;
        perr_next       = perr_reg;
        derr_next       = derr_reg;
        pp_next         = pp_reg;
        term_next       = term_reg;
        ib_next         = ib_reg;
        prev_next       = prev_reg;
        integ_next      = integ_reg;
        latch_next      = latch_reg;
        last_drive_next = last_drive_reg;
        last_sat_next   = last_sat_reg;
        out_valid_next  = out_valid_reg;
        out_drive_next  = out_drive_reg;
        out_sat_next    = out_sat_reg;
        mul_a           = pw_reg;
        mul_b           = ref_reg;
        div_req         = '0;
        change          = 64'(derr_reg) - 64'(prev_reg);
        filt            = tdp_pkg::sat32(64'(fc_reg) + 64'(div_rsp.quotient));
        sum             = tdp_pkg::sat32(64'(pp_reg) + 64'(ib_reg) + 64'(mul_res));
        clamped         = sum;

        // Drop the output once taken
        if (out_valid_reg && out_ch.ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                mul_b = in_ch.reference;
                if (in_fire) begin
                    cmd_next  = in_ch.command;
                    ref_next  = in_ch.reference;
                    fb_next   = in_ch.feedback;
                    dt_next   = in_ch.time_step;
                    ierr_next = tdp_pkg::sat32(64'(in_ch.reference) - 64'(in_ch.feedback));
                    if (in_ch.command == tdp_pkg::CMD_STANDBY) begin
                        latch_next = 1'b0;
                        state_next = ST_FIN;
                    end
                    else begin
                        if (in_ch.command == tdp_pkg::CMD_ARM) begin
                            prev_next  = '0;
                            integ_next = '0;
                        end
                        state_next = ST_PW;
                    end
                end
            end
            ST_PW: begin
                perr_next = (cmd_reg == tdp_pkg::CMD_ARM) ? 32'sd0 :
                            tdp_pkg::sat32(64'(mul_res) - 64'(fb_reg));
                mul_a      = dw_reg;
                mul_b      = ref_reg;
                state_next = ST_DW;
            end
            ST_DW: begin
                derr_next = (cmd_reg == tdp_pkg::CMD_ARM) ? 32'sd0 :
                            tdp_pkg::sat32(64'(mul_res) - 64'(fb_reg));
                mul_a      = pg_reg;
                mul_b      = perr_reg;
                state_next = ST_PP;
            end
            ST_PP: begin
                pp_next   = mul_res;
                prev_next = derr_reg;
                if (change == 64'sd0) begin
                    term_next  = '0;
                    state_next = ST_POST;
                end
                else begin
                    div_req.start    = 1'b1;
                    div_req.dividend = dt_s;
                    div_req.divisor  = tdp_pkg::sat32(change);
                    state_next       = ST_D1;
                end
            end
            ST_D1: begin
                if (div_rsp.done) begin
                    if (filt == 32'sd0) begin
                        term_next  = '0;
                        state_next = ST_POST;
                    end
                    else begin
                        div_req.start    = 1'b1;
                        div_req.dividend = tdp_pkg::FX_ONE;
                        div_req.divisor  = filt;
                        state_next       = ST_D2;
                    end
                end
            end
            ST_D2: begin
                if (div_rsp.done) begin
                    term_next  = div_rsp.quotient;
                    state_next = ST_POST;
                end
            end
            ST_POST: begin
                if (cmd_reg == tdp_pkg::CMD_ENGAGE && !latch_reg) begin
                    // Latch the integrator on first engage
                    latch_next = 1'b1;
                    if (ig_reg != 32'sd0) begin
                        div_req.start    = 1'b1;
                        div_req.dividend = tdp_pkg::sat32(64'sd0 - 64'(pp_reg));
                        div_req.divisor  = ig_reg;
                        state_next       = ST_DI;
                    end
                    else begin
                        integ_next = '0;
                        state_next = ST_UPD;
                    end
                end
                else if (cmd_reg == tdp_pkg::CMD_ENGAGE) begin
                    state_next = ST_UPD;
                end
                else begin
                    if (cmd_reg == tdp_pkg::CMD_ARM) begin
                        latch_next = 1'b1;
                    end
                    state_next = ST_O1;
                end
            end
            ST_DI: begin
                if (div_rsp.done) begin
                    integ_next = div_rsp.quotient;
                    state_next = ST_UPD;
                end
            end
            ST_UPD: begin
                mul_a = dt_s;
                mul_b = ierr_reg;
                if (ig_reg != 32'sd0) begin
                    state_next = ST_UPW;
                end
                else begin
                    integ_next = '0;
                    state_next = ST_O1;
                end
            end
            ST_UPW: begin
                integ_next = tdp_pkg::sat32(64'(integ_reg) + 64'(mul_res));
                state_next = ST_O1;
            end
            ST_O1: begin
                mul_a      = ig_reg;
                mul_b      = integ_reg;
                state_next = ST_O2;
            end
            ST_O2: begin
                ib_next    = mul_res;
                mul_a      = dg_reg;
                mul_b      = term_reg;
                state_next = ST_O3;
            end
            ST_O3: begin
                state_next = ST_FIN;
                if (tdp_pkg::SATURATE) begin
                    if (sum <= ll_reg) begin
                        clamped       = ll_reg;
                        last_sat_next = tdp_pkg::SAT_LOW;
                    end
                    else if (sum >= ul_reg) begin
                        clamped       = ul_reg;
                        last_sat_next = tdp_pkg::SAT_HIGH;
                    end
                    else begin
                        last_sat_next = tdp_pkg::SAT_FREE;
                    end
                    // Back-solve the integrator on a clamp
                    if (sum <= ll_reg || sum >= ul_reg) begin
                        if (ig_reg != 32'sd0) begin
                            div_req.start    = 1'b1;
                            div_req.dividend = tdp_pkg::sat32(64'(clamped) - 64'(pp_reg));
                            div_req.divisor  = ig_reg;
                            state_next       = ST_DC;
                        end
                        else begin
                            integ_next = '0;
                        end
                    end
                end
                last_drive_next = clamped;
            end
            ST_DC: begin
                if (div_rsp.done) begin
                    integ_next = div_rsp.quotient;
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                // Hold until the output register is free
                if (!out_valid_reg || out_ch.ready) begin
                    out_valid_next = 1'b1;
                    out_drive_next = last_drive_reg;
                    out_sat_next   = last_sat_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg      <= ST_IDLE;
            cmd_reg        <= '0;
            ref_reg        <= '0;
            fb_reg         <= '0;
            dt_reg         <= '0;
            ierr_reg       <= '0;
            perr_reg       <= '0;
            derr_reg       <= '0;
            pp_reg         <= '0;
            term_reg       <= '0;
            ib_reg         <= '0;
            prev_reg       <= '0;
            integ_reg      <= '0;
            latch_reg      <= 1'b0;
            last_drive_reg <= '0;
            last_sat_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_drive_reg  <= '0;
            out_sat_reg    <= '0;
        end
        else begin
            state_reg      <= state_next;
            cmd_reg        <= cmd_next;
            ref_reg        <= ref_next;
            fb_reg         <= fb_next;
            dt_reg         <= dt_next;
            ierr_reg       <= ierr_next;
            perr_reg       <= perr_next;
            derr_reg       <= derr_next;
            pp_reg         <= pp_next;
            term_reg       <= term_next;
            ib_reg         <= ib_next;
            prev_reg       <= prev_next;
            integ_reg      <= integ_next;
            latch_reg      <= latch_next;
            last_drive_reg <= last_drive_next;
            last_sat_reg   <= last_sat_next;
            out_valid_reg  <= out_valid_next;
            out_drive_reg  <= out_drive_next;
            out_sat_reg    <= out_sat_next;
        end
    end

    `include "assert_macros.svh"

    `TDP_ASSERT(a_busy_after_accept, in_fire |=> !in_ch.ready, "ready while busy")
    `TDP_NEVER(a_sat_code, out_ch.valid && out_ch.sat_status == 2'sb10, "bad sat code")
    `TDP_ASSERT(a_out_hold, out_valid_reg && !out_ch.ready |=> out_valid_reg, "result dropped")
    `TDP_NEVER(a_div_in_idle, state_reg == ST_IDLE && div_req.start, "divider start in idle")

endmodule
